// ----- hw/rtl/gice_pkg.sv -----
`timescale 1ns / 1ps

package gice_pkg;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ISO_VALUE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIND_MAX  = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic pair;
    logic neg;
    logic send;
  } job_ctrl_t;

  localparam int JOB_CTRL_W = $bits(job_ctrl_t);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_CMP  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

endpackage

// ----- hw/rtl/grid_isovalue_crossing_extreme.sv -----
`timescale 1ns / 1ps

// grid isovalue crossing extreme finder
// input channel: item_valid / item_ready with one grid sample per request
// (value, valid flag, coordinate along the line, line coordinate, line start,
// scan end). output channel: result_valid / result_ready, one result per
// request that carries scan_end: found flag, extreme crossing position and
// its line coordinate, all signed fixed point.
// configuration: cfg_write with cfg_index 0 = iso_value, 1 = find_max.
// a front stage keeps the previous sample, classifies the pair and queues a
// job (two entries); requests that make no crossing and end no scan are
// absorbed without a job. for each crossing pair a back stage runs a
// restoring divider and then a shift-add multiplier (both skipped when the
// iso value equals the newer sample), then a compare state; a job that only
// ends a scan goes straight to the emit state, which loads the result
// register.
// reset: iso_value 0, find_max 1, queue empty, no previous sample, no best.
// a stalled receiver holds the result register; the back stage then waits
// on the next result and the queue fills, after which item_ready drops.

module grid_isovalue_crossing_extreme #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gice_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [VALUE_WIDTH-1:0]          cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [VALUE_WIDTH-1:0]          sample_value,
  input  logic                            sample_valid,
  input  logic [VALUE_WIDTH-1:0]          grid_coord,
  input  logic [VALUE_WIDTH-1:0]          line_coord,
  input  logic                            line_start,
  input  logic                            scan_end,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            found,
  output logic [VALUE_WIDTH-1:0]          iso_position,
  output logic [VALUE_WIDTH-1:0]          assoc_coord
);

  localparam int JOB_W = 5 * VALUE_WIDTH + gice_pkg::JOB_CTRL_W;

  logic                   push;
  logic                   pop;
  logic                   full;
  logic                   empty;
  gice_pkg::job_ctrl_t    f_ctrl;
  logic [VALUE_WIDTH-1:0] f_n;
  logic [VALUE_WIDTH-1:0] f_d;
  logic [VALUE_WIDTH-1:0] f_dc;
  logic [VALUE_WIDTH-1:0] f_c0;
  logic [VALUE_WIDTH-1:0] f_oth;
  gice_pkg::job_ctrl_t    b_ctrl;
  logic [VALUE_WIDTH-1:0] b_n;
  logic [VALUE_WIDTH-1:0] b_d;
  logic [VALUE_WIDTH-1:0] b_dc;
  logic [VALUE_WIDTH-1:0] b_c0;
  logic [VALUE_WIDTH-1:0] b_oth;
  logic [JOB_W-1:0]       push_data;
  logic [JOB_W-1:0]       pop_data;

  gice_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .sample_value (sample_value),
    .sample_valid (sample_valid),
    .grid_coord   (grid_coord),
    .line_coord   (line_coord),
    .line_start   (line_start),
    .scan_end     (scan_end),
    .full         (full),
    .push         (push),
    .job_ctrl     (f_ctrl),
    .job_n        (f_n),
    .job_d        (f_d),
    .job_dc       (f_dc),
    .job_c0       (f_c0),
    .job_oth      (f_oth)
  );

  assign push_data = {f_ctrl, f_n, f_d, f_dc, f_c0, f_oth};
  assign {b_ctrl, b_n, b_d, b_dc, b_c0, b_oth} = pop_data;

  gice_fifo #(
    .WIDTH(JOB_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  gice_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .empty        (empty),
    .pop          (pop),
    .job_ctrl     (b_ctrl),
    .job_n        (b_n),
    .job_d        (b_d),
    .job_dc       (b_dc),
    .job_c0       (b_c0),
    .job_oth      (b_oth),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .found        (found),
    .iso_position (iso_position),
    .assoc_coord  (assoc_coord)
  );

endmodule

// ----- hw/rtl/gice_front.sv -----
`timescale 1ns / 1ps

module gice_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gice_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [VALUE_WIDTH-1:0]          cfg_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [VALUE_WIDTH-1:0]          sample_value,
  input  logic                            sample_valid,
  input  logic [VALUE_WIDTH-1:0]          grid_coord,
  input  logic [VALUE_WIDTH-1:0]          line_coord,
  input  logic                            line_start,
  input  logic                            scan_end,
  input  logic                            full,
  output logic                            push,
  output gice_pkg::job_ctrl_t             job_ctrl,
  output logic [VALUE_WIDTH-1:0]          job_n,
  output logic [VALUE_WIDTH-1:0]          job_d,
  output logic [VALUE_WIDTH-1:0]          job_dc,
  output logic [VALUE_WIDTH-1:0]          job_c0,
  output logic [VALUE_WIDTH-1:0]          job_oth
);

  logic [VALUE_WIDTH-1:0] iso_value;
  logic [VALUE_WIDTH-1:0] prev_value;
  logic [VALUE_WIDTH-1:0] prev_coord;
  logic                   prev_valid;

  logic                   accept;
  logic                   a_lt_b;
  logic                   in_range;
  logic                   pair_ok;
  logic [VALUE_WIDTH-1:0] lo;
  logic [VALUE_WIDTH-1:0] hi;

  assign item_ready = !full;
  assign accept     = item_valid && item_ready;

  always_comb begin
    a_lt_b   = $signed(prev_value) < $signed(sample_value);
    lo       = a_lt_b ? prev_value : sample_value;
    hi       = a_lt_b ? sample_value : prev_value;
    in_range = !($signed(iso_value) < $signed(lo)) && !($signed(hi) < $signed(iso_value));
    pair_ok  = sample_valid && prev_valid && !line_start &&
               (prev_value != sample_value) && in_range;

    job_ctrl.pair = pair_ok;
    job_ctrl.neg  = $signed(grid_coord) < $signed(prev_coord);
    job_ctrl.send = scan_end;
    job_d   = hi - lo;
    job_n   = a_lt_b ? (iso_value - prev_value) : (prev_value - iso_value);
    job_dc  = job_ctrl.neg ? (prev_coord - grid_coord) : (grid_coord - prev_coord);
    job_c0  = prev_coord;
    job_oth = line_coord;
  end

  assign push = accept && (pair_ok || scan_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      iso_value  <= '0;
      prev_valid <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == gice_pkg::CFG_ISO_VALUE) begin
        iso_value <= cfg_data;
      end
      if (accept) begin
        prev_valid <= sample_valid && !scan_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_value <= sample_value;
      prev_coord <= grid_coord;
    end
  end

endmodule

// ----- hw/rtl/gice_fifo.sv -----
`timescale 1ns / 1ps

module gice_fifo #(
  parameter int WIDTH = 163
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int DEPTH = gice_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("request pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_full_empty_excl: assert property (@(posedge clk) disable iff (rst) !(full && empty))
    else $error("queue both full and empty");

endmodule

// ----- hw/rtl/gice_back.sv -----
`timescale 1ns / 1ps

module gice_back #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gice_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [VALUE_WIDTH-1:0]          cfg_data,
  input  logic                            empty,
  output logic                            pop,
  input  gice_pkg::job_ctrl_t             job_ctrl,
  input  logic [VALUE_WIDTH-1:0]          job_n,
  input  logic [VALUE_WIDTH-1:0]          job_d,
  input  logic [VALUE_WIDTH-1:0]          job_dc,
  input  logic [VALUE_WIDTH-1:0]          job_c0,
  input  logic [VALUE_WIDTH-1:0]          job_oth,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            found,
  output logic [VALUE_WIDTH-1:0]          iso_position,
  output logic [VALUE_WIDTH-1:0]          assoc_coord
);

  localparam int CNT_W = $clog2(FRAC_BITS);

  gice_pkg::state_t state;

  logic                   find_max;
  logic                   neg;
  logic                   send;
  logic [VALUE_WIDTH-1:0] d;
  logic [VALUE_WIDTH-1:0] dc;
  logic [VALUE_WIDTH-1:0] c0;
  logic [VALUE_WIDTH-1:0] oth;
  logic [VALUE_WIDTH-1:0] r;
  logic [FRAC_BITS-1:0]   q;
  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] best_position;
  logic [VALUE_WIDTH-1:0] best_assoc;
  logic                   have_best;

  logic [VALUE_WIDTH:0]   r2;
  logic [VALUE_WIDTH:0]   rsub;
  logic                   ge;
  logic [VALUE_WIDTH:0]   sum;
  logic [VALUE_WIDTH-1:0] pos;
  logic                   update;
  logic                   last_step;
  logic                   load_result;

  always_comb begin
    r2     = {r, 1'b0};
    rsub   = r2 - {1'b0, d};
    ge     = r2 >= {1'b0, d};
    sum    = {1'b0, acc} + (q[0] ? {1'b0, dc} : '0);
    pos    = neg ? (c0 - acc) : (c0 + acc);
    if (!have_best) begin
      update = 1'b1;
    end else if (find_max) begin
      update = $signed(best_position) < $signed(pos);
    end else begin
      update = $signed(pos) < $signed(best_position);
    end
    last_step   = cnt == CNT_W'(FRAC_BITS - 1);
    pop         = (state == gice_pkg::S_IDLE) && !empty;
    load_result = (state == gice_pkg::S_EMIT) && (!result_valid || result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gice_pkg::S_IDLE;
      find_max     <= 1'b1;
      have_best    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == gice_pkg::CFG_FIND_MAX) begin
        find_max <= cfg_data[0];
      end
      if (result_valid && result_ready && !load_result) begin
        result_valid <= 1'b0;
      end
      case (state)
        gice_pkg::S_IDLE: begin
          if (pop) begin
            if (!job_ctrl.pair) begin
              state <= gice_pkg::S_EMIT;
            end else if (job_n >= job_d) begin
              state <= gice_pkg::S_CMP;
            end else begin
              state <= gice_pkg::S_DIV;
            end
          end
        end
        gice_pkg::S_DIV: begin
          if (last_step) begin
            state <= gice_pkg::S_MUL;
          end
        end
        gice_pkg::S_MUL: begin
          if (last_step) begin
            state <= gice_pkg::S_CMP;
          end
        end
        gice_pkg::S_CMP: begin
          if (update) begin
            have_best <= 1'b1;
          end
          state <= send ? gice_pkg::S_EMIT : gice_pkg::S_IDLE;
        end
        gice_pkg::S_EMIT: begin
          if (load_result) begin
            result_valid <= 1'b1;
            have_best    <= 1'b0;
            state        <= gice_pkg::S_IDLE;
          end
        end
        default: begin
          state <= gice_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gice_pkg::S_IDLE: begin
        if (pop) begin
          neg  <= job_ctrl.neg;
          send <= job_ctrl.send;
          d    <= job_d;
          dc   <= job_dc;
          c0   <= job_c0;
          oth  <= job_oth;
          r    <= job_n;
          cnt  <= '0;
          acc  <= (job_n >= job_d) ? job_dc : '0;
        end
      end
      gice_pkg::S_DIV: begin
        r   <= ge ? rsub[VALUE_WIDTH-1:0] : r2[VALUE_WIDTH-1:0];
        q   <= {q[FRAC_BITS-2:0], ge};
        cnt <= last_step ? '0 : cnt + 1'b1;
      end
      gice_pkg::S_MUL: begin
        acc <= sum[VALUE_WIDTH:1];
        q   <= q >> 1;
        cnt <= last_step ? '0 : cnt + 1'b1;
      end
      gice_pkg::S_CMP: begin
        if (update) begin
          best_position <= pos;
          best_assoc    <= oth;
        end
      end
      gice_pkg::S_EMIT: begin
        if (load_result) begin
          found        <= have_best;
          iso_position <= have_best ? best_position : '0;
          assoc_coord  <= have_best ? best_assoc : '0;
        end
      end
      default: begin
      end
    endcase
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == gice_pkg::S_DIV |-> r < d)
    else $error("divider remainder not below divisor");
  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    state == gice_pkg::S_MUL |-> acc <= dc)
    else $error("offset accumulator exceeds coordinate span");
  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    load_result |=> !have_best && result_valid)
    else $error("search not cleared after result");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

typedef struct packed {
  logic [31:0] value;
  logic        present;
  logic [31:0] grid_pos;
  logic [31:0] line_pos;
  logic        line_first;
  logic        scan_last;
} grid_sample_t;

typedef struct packed {
  logic        found;
  logic [31:0] position;
  logic [31:0] assoc;
} scan_result_t;

class crossing_tracker;
  logic [31:0]  iso;
  logic         keep_max;
  logic [31:0]  last_value;
  logic [31:0]  last_coord;
  logic         last_present;
  logic [31:0]  best_pos;
  logic [31:0]  best_line;
  logic         have_best;
  scan_result_t expected_scans[$];
  int           errors;

  function new();
    iso = '0;
    keep_max = 1'b1;
    last_value = '0;
    last_coord = '0;
    last_present = 1'b0;
    best_pos = '0;
    best_line = '0;
    have_best = 1'b0;
    errors = 0;
  endfunction

  function void set_config(logic [gice_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    if (idx == gice_pkg::CFG_ISO_VALUE)
      iso = data;
    else if (idx == gice_pkg::CFG_FIND_MAX)
      keep_max = data[0];
  endfunction

  // interpolated crossing between two neighbors, folded into the running extreme
  function void fold_pair(logic [31:0] a, logic [31:0] b, logic [31:0] c0,
                          logic [31:0] c1, logic [31:0] lc);
    logic [31:0] lo, hi, n, d, dc, off, pos;
    logic [63:0] t, prod;
    logic        better;
    if (a == b)
      return;
    if ($signed(a) < $signed(b)) begin
      lo = a;
      hi = b;
      n = iso - a;
    end else begin
      lo = b;
      hi = a;
      n = a - iso;
    end
    if ($signed(iso) < $signed(lo) || $signed(hi) < $signed(iso))
      return;
    d = hi - lo;
    t = (n >= d) ? 64'h1_0000 : ({32'h0, n} << 16) / {32'h0, d};
    dc = ($signed(c1) < $signed(c0)) ? c0 - c1 : c1 - c0;
    prod = {32'h0, dc} * t;
    off = prod[47:16];
    pos = ($signed(c1) < $signed(c0)) ? c0 - off : c0 + off;
    if (!have_best)
      better = 1'b1;
    else if (keep_max)
      better = $signed(best_pos) < $signed(pos);
    else
      better = $signed(pos) < $signed(best_pos);
    if (better) begin
      best_pos = pos;
      best_line = lc;
      have_best = 1'b1;
    end
  endfunction

  function void note_sample(grid_sample_t s);
    scan_result_t r;
    if (s.line_first)
      last_present = 1'b0;
    if (s.present && last_present)
      fold_pair(last_value, s.value, last_coord, s.grid_pos, s.line_pos);
    last_value = s.value;
    last_coord = s.grid_pos;
    last_present = s.present;
    if (s.scan_last) begin
      r.found = have_best;
      r.position = have_best ? best_pos : '0;
      r.assoc = have_best ? best_line : '0;
      expected_scans.push_back(r);
      have_best = 1'b0;
      best_pos = '0;
      best_line = '0;
      last_present = 1'b0;
    end
  endfunction

  function void report(string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endfunction

  function void check_result(logic f, logic [31:0] p, logic [31:0] a);
    scan_result_t e;
    if (expected_scans.size() == 0) begin
      report("result with no scan pending");
      return;
    end
    e = expected_scans.pop_front();
    if (f !== e.found)
      report($sformatf("found %b, expected %b", f, e.found));
    if (p !== e.position)
      report($sformatf("iso_position %h, expected %h", p, e.position));
    if (a !== e.assoc)
      report($sformatf("assoc_coord %h, expected %h", a, e.assoc));
  endfunction
endclass

module tb_top;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [gice_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 item_valid;
  logic                 item_ready;
  logic [31:0]          sample_value;
  logic                 sample_valid;
  logic [31:0]          grid_coord;
  logic [31:0]          line_coord;
  logic                 line_start;
  logic                 scan_end;
  logic                 result_valid;
  logic                 result_ready;
  logic                 found;
  logic [31:0]          iso_position;
  logic [31:0]          assoc_coord;

  crossing_tracker tracker;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_requests = 0;
  int items_sent = 0;

  grid_isovalue_crossing_extreme dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .sample_value (sample_value),
    .sample_valid (sample_valid),
    .grid_coord   (grid_coord),
    .line_coord   (line_coord),
    .line_start   (line_start),
    .scan_end     (scan_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .found        (found),
    .iso_position (iso_position),
    .assoc_coord  (assoc_coord)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls plus the long hold-off on request
  initial begin
    int  hold_left;
    int  served;
    bit  rdy;
    hold_left = 0;
    served = 0;
    forever begin
      if (served != hold_requests) begin
        served = hold_requests;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end else begin
        rdy = ($urandom_range(0, 99) >= rx_stall_pct);
      end
      result_ready <= rdy;
      @(posedge clk);
      if (!rst && result_valid && rdy)
        tracker.check_result(found, iso_position, assoc_coord);
    end
  end

  task automatic send_sample(grid_sample_t s);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid   <= 1'b1;
    sample_value <= s.value;
    sample_valid <= s.present;
    grid_coord   <= s.grid_pos;
    line_coord   <= s.line_pos;
    line_start   <= s.line_first;
    scan_end     <= s.scan_last;
    @(posedge clk);
    while (!item_ready)
      @(posedge clk);
    tracker.note_sample(s);
    items_sent++;
  endtask

  task automatic put(logic [31:0] v, logic ok, logic [31:0] gc, logic [31:0] lc,
                     logic ls, logic se);
    grid_sample_t s;
    s.value = v;
    s.present = ok;
    s.grid_pos = gc;
    s.line_pos = lc;
    s.line_first = ls;
    s.scan_last = se;
    send_sample(s);
  endtask

  task automatic write_reg(logic [gice_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.set_config(idx, data);
    @(posedge clk);
  endtask

  // wait for every pending scan result, then let queued pair work finish
  task automatic settle();
    while (tracker.expected_scans.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic send_noise();
    grid_sample_t s;
    s.value = $urandom;
    s.present = $urandom_range(0, 1);
    s.grid_pos = $urandom;
    s.line_pos = $urandom;
    s.line_first = $urandom_range(0, 1);
    s.scan_last = ($urandom_range(0, 7) == 0);
    send_sample(s);
  endtask

  task automatic run_scan(bit closing, bit wild);
    int           nlines;
    int           nsamp;
    grid_sample_t s;
    logic [31:0]  gc, step, lc, v;
    nlines = $urandom_range(1, 4);
    v = tracker.iso;
    for (int l = 0; l < nlines; l++) begin
      nsamp = $urandom_range(2, 8);
      lc = wild ? $urandom : $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      gc = wild ? $urandom : $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      step = wild ? $urandom : $urandom_range(1, 32'h0004_0000);
      if (!wild && $urandom_range(0, 1))
        step = -step;
      for (int i = 0; i < nsamp; i++) begin
        case ($urandom_range(0, 9))
          0: ;
          1: v = tracker.iso;
          default: begin
            if (wild)
              v = $urandom;
            else
              v = tracker.iso + $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
          end
        endcase
        s.value = v;
        s.present = ($urandom_range(0, 9) != 0);
        s.grid_pos = gc;
        s.line_pos = lc;
        s.line_first = (i == 0);
        s.scan_last = closing && (l == nlines - 1) && (i == nsamp - 1);
        send_sample(s);
        gc = gc + step;
      end
    end
  endtask

  task automatic run_directed();
    put(32'hFFFF_0000, 1, 32'h0000_0000, 32'h0005_0000, 1, 0);
    put(32'h0001_0000, 1, 32'h0002_0000, 32'h0005_0000, 0, 0);
    put(32'h0001_0000, 1, 32'h0003_0000, 32'h0005_0000, 0, 0);
    put(32'h0000_0000, 0, 32'h0004_0000, 32'h0005_0000, 0, 0);
    put(32'hFFFD_0000, 1, 32'h0005_0000, 32'h0005_0000, 0, 0);
    put(32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0);
    put(32'h7FFF_FFFF, 1, 32'h8000_0000, 32'h8000_0000, 0, 0);
    put(32'h0000_0000, 1, 32'h0000_0000, 32'h1234_0000, 1, 0);
    put(32'h0000_0000, 1, 32'h0001_0000, 32'h1234_0000, 0, 0);
    put(32'h0004_0000, 1, 32'h0002_0000, 32'h1234_0000, 0, 0);
    put(32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1);
    put(32'h0000_0005, 1, 32'h0000_0003, 32'h0000_0004, 1, 1);
    put(32'hFFFF_FFFF, 1, 32'h0000_0000, 32'h0000_000A, 1, 0);
    put(32'h0000_0001, 1, 32'h0002_0000, 32'h0000_000A, 0, 0);
    put(32'hFFFF_FFFF, 1, 32'h0000_0000, 32'h0000_000B, 1, 0);
    put(32'h0000_0001, 1, 32'h0002_0000, 32'h0000_000B, 0, 1);
    put(32'h0002_0000, 1, 32'h0000_0000, 32'h0000_000C, 0, 0);
    put(32'hFFFE_0000, 1, 32'h0001_0000, 32'h0000_000C, 0, 0);
    put(32'h0003_0000, 1, 32'h0002_0000, 32'h0000_000D, 1, 0);
    put(32'hFFFE_0000, 0, 32'h0003_0000, 32'h0000_000D, 0, 1);
    item_valid <= 1'b0;
  endtask

  task automatic run_phase(int p);
    int          start;
    logic [31:0] iso;
    logic [31:0] mode;
    case (p)
      1: iso = 32'h8000_0000;
      2: iso = 32'h7FFF_FFFF;
      3: iso = $urandom;
      5: iso = 32'h0000_0000;
      default: iso = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
    mode = $urandom & 32'hFFFF_FFFE;
    if (p < 4)
      mode[0] = p[0];
    else
      mode[0] = $urandom_range(0, 1);
    write_reg(gice_pkg::CFG_ISO_VALUE, iso);
    write_reg(gice_pkg::CFG_FIND_MAX, mode);
    case (p % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
      default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
    endcase
    if (p == 4)
      hold_requests++;
    start = items_sent;
    while (items_sent - start < 200) begin
      if ($urandom_range(0, 4) == 0)
        send_noise();
      else
        run_scan(1'b1, $urandom_range(0, 7) == 0);
    end
    // leave a scan open so the next setting lands mid-scan
    if (p % 2 == 1)
      run_scan(1'b0, 1'b0);
    item_valid <= 1'b0;
  endtask

  initial begin
    tracker = new();
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    item_valid   <= 1'b0;
    sample_value <= '0;
    sample_valid <= 1'b0;
    grid_coord   <= '0;
    line_coord   <= '0;
    line_start   <= 1'b0;
    scan_end     <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < 8; p++) begin
      settle();
      run_phase(p);
    end
    settle();
    if (tracker.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/gice_pkg.sv
hw/rtl/gice_front.sv
hw/rtl/gice_fifo.sv
hw/rtl/gice_back.sv
hw/rtl/grid_isovalue_crossing_extreme.sv
verif/tb_top.sv
